>>> rtl/pia_pkg.sv
`default_nettype none
package pia_pkg;

	localparam int CAPACITY  = 16;
	localparam int WORD_BITS = 64;

	// fixed field widths
	localparam int ACT_BITS  = 2;
	localparam int IDX_BITS  = 5;
	localparam int DATA_BITS = 64;
	localparam int STAT_BITS = 2;
	localparam int CNT_BITS  = 5;

	localparam int IN_BITS   = ACT_BITS + IDX_BITS + DATA_BITS;
	localparam int OUT_BITS  = DATA_BITS + STAT_BITS + CNT_BITS;
	localparam int IN_BYTES  = (IN_BITS + 7) / 8;
	localparam int OUT_BYTES = (OUT_BITS + 7) / 8;

	// internal widths
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int POS_W = $clog2(CAPACITY);
	localparam int CMP_W = (CNT_W > IDX_BITS) ? CNT_W : IDX_BITS;

	localparam logic [ACT_BITS-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACT_BITS-1:0] ACT_ERASE  = 2'd1;
	localparam logic [ACT_BITS-1:0] ACT_READ   = 2'd2;

	localparam logic [STAT_BITS-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_BITS-1:0] ST_RANGE = 2'd1;
	localparam logic [STAT_BITS-1:0] ST_FULL  = 2'd2;

	// broadcast to every cell; ins/ers are set only for in-range requests
	typedef struct packed {
		logic             ins;
		logic             ers;
		logic [CMP_W-1:0] idx;
	} pia_op_t;

endpackage
`default_nettype wire

>>> rtl/pia_cell.sv
`default_nettype none
module pia_cell import pia_pkg::*; (
	input  wire                  clk,
	input  wire pia_op_t         op,
	input  wire [CMP_W-1:0]      pos,
	input  wire [WORD_BITS-1:0]  value,
	input  wire [WORD_BITS-1:0]  left,
	input  wire [WORD_BITS-1:0]  right,
	output logic [WORD_BITS-1:0] word
);

	logic [WORD_BITS-1:0] word_q;

	always_ff @(posedge clk) begin
		if (op.ins && pos == op.idx) begin
			word_q <= value;
		end else if (op.ins && pos > op.idx) begin
			word_q <= left;
		end else if (op.ers && pos >= op.idx) begin
			word_q <= right;
		end
	end

	assign word = word_q;

endmodule
`default_nettype wire

>>> rtl/positional_insert_erase_array.sv
// Positional insert/erase array of CAPACITY words.
// Input stream s_*: one request per transfer (insert, erase or read at an
// index). Output stream m_*: exactly one result per request, in order,
// carrying read data, a status code and the entry count after the action.
// Insert at index <= count into a non-full array shifts the entries at
// and above index up one place and stores the word; erase at index <
// count shifts the entries above index down one place. Every cell of the
// row moves in the same cycle.
// The result is registered, shown the cycle after the request transfer.
// Throughput: one request per cycle while m_tready is high; the single
// output register lets a new request in during the cycle its result leaves.
// When the receiver stalls, the result is held in the output register and
// s_tready drops until it is taken.
// Reset clears the count and the output valid; the stored words are not
// cleared, and only positions below the count are ever read.
`default_nettype none
module positional_insert_erase_array import pia_pkg::*; (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   s_tvalid,
	output logic                  s_tready,
	// action[1:0], index[6:2], value[70:7], zero[71]
	input  wire [IN_BYTES*8-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  wire                   m_tready,
	// read_data[63:0], status[65:64], count[70:66], zero[71]
	output logic [OUT_BYTES*8-1:0] m_tdata
);

	logic [ACT_BITS-1:0]  action;
	logic [IDX_BITS-1:0]  index;
	logic [DATA_BITS-1:0] value_in;
	logic [WORD_BITS-1:0] value_w;

	assign action   = s_tdata[ACT_BITS-1:0];
	assign index    = s_tdata[ACT_BITS +: IDX_BITS];
	assign value_in = s_tdata[ACT_BITS+IDX_BITS +: DATA_BITS];
	assign value_w  = value_in[WORD_BITS-1:0];

	logic                 accept;
	logic [CNT_W-1:0]     count_q;
	logic [CMP_W-1:0]     idx_e;
	logic [CMP_W-1:0]     cnt_e;
	logic                 full;
	logic [STAT_BITS-1:0] status;
	logic [CNT_W-1:0]     count_nxt;
	pia_op_t              op;
	logic [WORD_BITS-1:0] words [CAPACITY];
	logic [POS_W-1:0]     rd_pos;
	logic [DATA_BITS-1:0] rd_data;

	logic                 out_valid_q;
	logic [DATA_BITS-1:0] rd_data_q;
	logic [STAT_BITS-1:0] status_q;
	logic [CMP_W-1:0]     count_out_q;

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign idx_e  = CMP_W'(index);
	assign cnt_e  = CMP_W'(count_q);
	assign full   = (count_q == CNT_W'(CAPACITY));
	assign rd_pos = idx_e[POS_W-1:0];

	always_comb begin
		status    = ST_OK;
		count_nxt = count_q;
		op.ins    = 1'b0;
		op.ers    = 1'b0;
		op.idx    = idx_e;
		rd_data   = '0;
		case (action)
			ACT_INSERT: begin
				if (idx_e > cnt_e) begin
					status = ST_RANGE;
				end else if (full) begin
					status = ST_FULL;
				end else begin
					op.ins    = accept;
					count_nxt = count_q + 1'b1;
				end
			end
			ACT_ERASE: begin
				if (idx_e >= cnt_e) begin
					status = ST_RANGE;
				end else begin
					op.ers    = accept;
					count_nxt = count_q - 1'b1;
				end
			end
			ACT_READ: begin
				if (idx_e >= cnt_e) begin
					status = ST_RANGE;
				end else begin
					rd_data = DATA_BITS'(words[rd_pos]);
				end
			end
			default: begin
				status = ST_RANGE;
			end
		endcase
	end

	// row of cells; ends see zero from the missing neighbor
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [WORD_BITS-1:0] left;
		logic [WORD_BITS-1:0] right;
		if (i == 0) begin : g_first
			assign left = '0;
		end else begin : g_mid_l
			assign left = words[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right = '0;
		end else begin : g_mid_r
			assign right = words[i+1];
		end
		pia_cell u_cell (
			.clk   (clk),
			.op    (op),
			.pos   (CMP_W'(i)),
			.value (value_w),
			.left  (left),
			.right (right),
			.word  (words[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_nxt;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_data_q   <= rd_data;
			status_q    <= status;
			count_out_q <= CMP_W'(count_nxt);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_BYTES*8-OUT_BITS){1'b0}},
		count_out_q[CNT_BITS-1:0], status_q, rd_data_q};

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("count above capacity");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		op.ins |=> count_q == $past(count_q) + 1'b1)
		else $error("insert did not grow count");

	a_erase_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		op.ers |=> count_q == $past(count_q) - 1'b1)
		else $error("erase did not shrink count");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != ST_OK) |-> rd_data_q == '0)
		else $error("error result carries data");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> m_tvalid)
		else $error("accepted request gave no result");

endmodule
`default_nettype wire
